FILE: hw/rtl/cspu_pkg.sv
`timescale 1ns / 1ps

package cspu_pkg;

  localparam int unsigned NUM_GROUPS  = 16;
  localparam int unsigned FRAME_BYTES = 8;
  localparam int unsigned ROW_W       = FRAME_BYTES * 8;
  localparam int unsigned GRP_W       = 4;

  // quotient bits retired per divider iteration
  localparam int unsigned DIV_STEP_BITS = 4;
  localparam int unsigned DIV_ITERS     = 32 / DIV_STEP_BITS;
  localparam int unsigned DIV_CNT_W     = $clog2(DIV_ITERS);

  typedef enum logic [1:0] {
    OP_PACK    = 2'd0,
    OP_UNPACK  = 2'd1,
    OP_WR_BYTE = 2'd2,
    OP_RD_BYTE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_RANGE       = 2'd1,
    STATUS_ZERO_FACTOR = 2'd2
  } status_e;

  typedef struct packed {
    op_e              op;
    logic [GRP_W-1:0] group_index;
    logic [3:0]       group_length;
    logic [5:0]       start_bit;
    logic [5:0]       bit_length;
    logic [15:0]      scale_factor;
    logic [31:0]      scale_offset;
    logic [31:0]      write_value;
    logic [2:0]       byte_index;
    logic [7:0]       byte_in;
    logic             event_triggered;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] read_value;
    logic [7:0]  byte_out;
    logic        send_request;
  } res_t;

endpackage

FILE: hw/rtl/cspu_div.sv
`timescale 1ns / 1ps

module cspu_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [15:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quotient_o
);

  logic [31:0] quo_q, quo_d;
  logic [15:0] rem_q, rem_d;
  logic [15:0] dvs_q;
  logic [cspu_pkg::DIV_CNT_W-1:0] cnt_q;
  logic busy_q, done_q;

  // restoring division, several quotient bits per cycle
  always_comb begin
    logic [16:0] trial;
    logic        ge;
    quo_d = quo_q;
    rem_d = rem_q;
    for (int k = 0; k < int'(cspu_pkg::DIV_STEP_BITS); k++) begin
      trial = {rem_d, quo_d[31]};
      ge    = (trial >= {1'b0, dvs_q});
      quo_d = {quo_d[30:0], ge};
      rem_d = ge ? 16'(trial - {1'b0, dvs_q}) : trial[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + cspu_pkg::DIV_CNT_W'(1);
        if (cnt_q == cspu_pkg::DIV_CNT_W'(cspu_pkg::DIV_ITERS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: hw/rtl/can_signal_pack_unpack_core.sv
`timescale 1ns / 1ps

// CAN signal store: 16 message groups of 8 frame bytes, one 64-bit row per group in a
// synchronous RAM, all zero after reset. An op is taken when start_i is high and busy_o
// low; its result appears on res_o with done_o high for exactly one cycle and must be
// taken then. Pack, raw write and raw read pass through row read, scale/saturate, and
// merge and write back. Unpack does the same row read and extract; if its checks pass, a
// divider then retires 4 quotient bits a cycle. A new op may be started in the cycle
// its predecessor's result is shown.
module can_signal_pack_unpack_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  cspu_pkg::req_t   req_i,
  output logic             done_o,
  output cspu_pkg::res_t   res_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_WB   = 2'd2;
  localparam logic [1:0] ST_DIV  = 2'd3;

  localparam int unsigned RW = cspu_pkg::ROW_W;

  logic [1:0] state_q, state_d;
  logic       accept;

  cspu_pkg::req_t req_q;
  logic [47:0]    prod_q;

  // row store and its per-row valid bits
  logic [RW-1:0] mem_q [cspu_pkg::NUM_GROUPS];
  logic [cspu_pkg::NUM_GROUPS-1:0] vld_q;
  logic [RW-1:0] rd_row_q;
  logic          rd_vld_q;
  logic          wr_en;
  logic [RW-1:0] wr_row;

  cspu_pkg::status_e status_q, status_d;
  logic [31:0] val_q, val_d;

  cspu_pkg::res_t res_q, res_d;
  logic           done_q, done_d;

  logic        div_start, div_done;
  logic [31:0] div_quo;

  logic [RW-1:0] row;
  logic [3:0]    glen_eff;
  logic [31:0]   fmask;
  logic [6:0]    last_bit;
  logic          grp_bad, len_bad;
  logic [48:0]   scaled;
  logic [31:0]   field, fld_raw;
  logic [RW-1:0] wmask, wword;

  assign accept = start_i && (state_q == ST_IDLE);
  assign busy_o = (state_q != ST_IDLE);

  // signal geometry, shared by the check and the merge
  always_comb begin
    glen_eff = (req_q.group_length > 4'(cspu_pkg::FRAME_BYTES)) ?
               4'(cspu_pkg::FRAME_BYTES) : req_q.group_length;
    fmask    = 32'hFFFF_FFFF >> (6'd32 - req_q.bit_length);
    last_bit = 7'(req_q.start_bit) + 7'(req_q.bit_length) - 7'd1;
    grp_bad  = ({1'b0, req_q.group_index} >= 5'(cspu_pkg::NUM_GROUPS));
    len_bad  = (req_q.bit_length == 6'd0) || (req_q.bit_length > 6'd32);
    row      = rd_vld_q ? rd_row_q : '0;
    scaled   = {1'b0, prod_q} + 49'(req_q.scale_offset);
    fld_raw  = 32'(row >> req_q.start_bit);
    field    = fld_raw & fmask;
    wmask    = RW'(fmask) << req_q.start_bit;
    wword    = RW'(val_q) << req_q.start_bit;
  end

  // status, and saturated pack value or offset-corrected unpack field
  always_comb begin
    status_d = cspu_pkg::STATUS_OK;
    if (grp_bad) begin
      status_d = cspu_pkg::STATUS_RANGE;
    end else if (req_q.op inside {cspu_pkg::OP_WR_BYTE, cspu_pkg::OP_RD_BYTE}) begin
      if ({1'b0, req_q.byte_index} >= glen_eff) status_d = cspu_pkg::STATUS_RANGE;
    end else if (len_bad || (last_bit[6:3] >= glen_eff)) begin
      status_d = cspu_pkg::STATUS_RANGE;
    end else if (req_q.scale_factor == 16'd0) begin
      status_d = cspu_pkg::STATUS_ZERO_FACTOR;
    end

    if (req_q.op == cspu_pkg::OP_PACK) begin
      val_d = (scaled > {17'd0, fmask}) ? fmask : scaled[31:0];
    end else begin
      val_d = (field > req_q.scale_offset) ? (field - req_q.scale_offset) : 32'd0;
    end
  end

  always_comb begin
    state_d   = state_q;
    wr_en     = 1'b0;
    wr_row    = row;
    div_start = 1'b0;
    done_d    = 1'b0;
    res_d     = '0;
    res_d.status = status_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_CALC;
      end
      ST_CALC: begin
        state_d = ST_WB;
      end
      ST_WB: begin
        state_d = ST_IDLE;
        done_d  = 1'b1;
        case (req_q.op)
          cspu_pkg::OP_PACK: begin
            if (status_q == cspu_pkg::STATUS_OK) begin
              wr_en  = 1'b1;
              wr_row = (row & ~wmask) | (wword & wmask);
              res_d.send_request = req_q.event_triggered;
            end
          end
          cspu_pkg::OP_UNPACK: begin
            if (status_q == cspu_pkg::STATUS_OK) begin
              div_start = 1'b1;
              done_d    = 1'b0;
              state_d   = ST_DIV;
            end
          end
          cspu_pkg::OP_WR_BYTE: begin
            if (status_q == cspu_pkg::STATUS_OK) begin
              wr_en = 1'b1;
              wr_row[{req_q.byte_index, 3'b000} +: 8] = req_q.byte_in;
            end
          end
          cspu_pkg::OP_RD_BYTE: begin
            if (status_q == cspu_pkg::STATUS_OK) begin
              res_d.byte_out = row[{req_q.byte_index, 3'b000} +: 8];
            end
          end
          default: ;
        endcase
      end
      ST_DIV: begin
        if (div_done) begin
          res_d.read_value = div_quo;
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
      vld_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (wr_en) vld_q[req_q.group_index] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q    <= req_i;
      prod_q   <= 48'(req_i.write_value) * 48'(req_i.scale_factor);
      rd_row_q <= mem_q[req_i.group_index];
      rd_vld_q <= vld_q[req_i.group_index];
    end
    if (wr_en) mem_q[req_q.group_index] <= wr_row;
    if (state_q == ST_CALC) begin
      status_q <= status_d;
      val_q    <= val_d;
    end
    if (done_d) res_q <= res_d;
  end

  cspu_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (val_q),
    .divisor_i  (req_q.scale_factor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

FILE: hw/rtl/cspu_checker.sv
`timescale 1ns / 1ps

module cspu_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start_i,
  input logic           busy_o,
  input logic           done_o,
  input cspu_pkg::res_t res_o
);

  // a transfer always leads to a busy period
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("no busy after start transfer");

  // results are shown only once the op has left the datapath
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result shown while busy");

  // every op passes through the calc and write-back states, so strobes never sit back to back
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (res_o.status != cspu_pkg::STATUS_OK) |->
      !res_o.send_request && (res_o.read_value == 32'd0) && (res_o.byte_out == 8'd0))
    else $error("failed op carries data");

endmodule

bind can_signal_pack_unpack_core cspu_checker u_cspu_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .done_o  (done_o),
  .res_o   (res_o)
);
